/* src/rne_pkg.sv */
// Package with the shared types, letter codes and pattern functions of the Roman numeral encoder.
package rne_pkg;

	localparam int unsigned NUM_W = 12;
	localparam int unsigned LETTER_W = 7;
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned QUOT_W = 9;
	localparam int unsigned PROD_W = 24;
	localparam int unsigned RECIP_SHIFT = 15;

	localparam logic [NUM_W-1:0] RECIP_TEN = 12'd3277;

	localparam logic [LETTER_W-1:0] CODE_NL = 7'd10;
	localparam logic [LETTER_W-1:0] CODE_I = 7'd73;
	localparam logic [LETTER_W-1:0] CODE_V = 7'd86;
	localparam logic [LETTER_W-1:0] CODE_X = 7'd88;
	localparam logic [LETTER_W-1:0] CODE_L = 7'd76;
	localparam logic [LETTER_W-1:0] CODE_C = 7'd67;
	localparam logic [LETTER_W-1:0] CODE_D = 7'd68;
	localparam logic [LETTER_W-1:0] CODE_M = 7'd77;

	localparam logic [1:0] POS_UNITS = 2'd0;
	localparam logic [1:0] POS_TENS = 2'd1;
	localparam logic [1:0] POS_HUNDREDS = 2'd2;
	localparam logic [1:0] POS_THOUSANDS = 2'd3;
	localparam logic [1:0] SPLIT_LAST = 2'd2;

	typedef enum logic [1:0] {
		SYM_ONE  = 2'd0,
		SYM_FIVE = 2'd1,
		SYM_TEN  = 2'd2
	} rne_sym_t;

	typedef struct packed {
		logic load;
		logic split;
		logic next_digit;
		logic step;
		logic newline;
	} rne_cmd_t;

	typedef struct packed {
		logic split_last;
		logic digit_done;
		logic last_digit;
		logic out_free;
	} rne_status_t;

	function automatic logic [2:0] digit_len(input logic [1:0] pos, input logic [DIGIT_W-1:0] dig);
		logic [2:0] len;
		len = 3'd0;
		if (pos == POS_THOUSANDS) begin
			if (dig >= 4'd1 && dig <= 4'd3) begin
				len = dig[2:0];
			end
		end else begin
			case (dig)
				4'd1: len = 3'd1;
				4'd2: len = 3'd2;
				4'd3: len = 3'd3;
				4'd4: len = 3'd2;
				4'd5: len = 3'd1;
				4'd6: len = 3'd2;
				4'd7: len = 3'd3;
				4'd8: len = 3'd4;
				4'd9: len = 3'd2;
				default: len = 3'd0;
			endcase
		end
		return len;
	endfunction

	function automatic logic [LETTER_W-1:0] letter_code(input logic [1:0] pos,
		input logic [DIGIT_W-1:0] dig, input logic [2:0] k);
		rne_sym_t sym;
		logic [LETTER_W-1:0] code;
		sym = SYM_ONE;
		case (dig)
			4'd4: sym = (k == 3'd0) ? SYM_ONE : SYM_FIVE;
			4'd5, 4'd6, 4'd7, 4'd8: sym = (k == 3'd0) ? SYM_FIVE : SYM_ONE;
			4'd9: sym = (k == 3'd0) ? SYM_ONE : SYM_TEN;
			default: sym = SYM_ONE;
		endcase
		case (pos)
			POS_UNITS: code = (sym == SYM_ONE) ? CODE_I : ((sym == SYM_FIVE) ? CODE_V : CODE_X);
			POS_TENS: code = (sym == SYM_ONE) ? CODE_X : ((sym == SYM_FIVE) ? CODE_L : CODE_C);
			POS_HUNDREDS: code = (sym == SYM_ONE) ? CODE_C : ((sym == SYM_FIVE) ? CODE_D : CODE_M);
			default: code = CODE_M;
		endcase
		return code;
	endfunction

endpackage

/* src/rne_in_if.sv */
// Input channel carrying the binary number word.
interface rne_in_if;
	logic valid;
	logic ready;
	logic [rne_pkg::NUM_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

/* src/rne_out_if.sv */
// Output channel carrying one numeral letter word.
interface rne_out_if;
	logic valid;
	logic ready;
	logic [rne_pkg::LETTER_W-1:0] letter;
	logic last_letter;

	modport source (output valid, output letter, output last_letter, input ready);
	modport sink (input valid, input letter, input last_letter, output ready);
endinterface

/* src/rne_ctrl.sv */
// Controller state machine that sequences digit splitting and letter emission.
module rne_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rne_pkg::rne_status_t status,
	output rne_pkg::rne_cmd_t    cmd
);
	import rne_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SPLIT = 4'b0010,
		S_EMIT  = 4'b0100,
		S_NL    = 4'b1000
	} rne_state_t;

	rne_state_t state_q;
	rne_state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_SPLIT;
				end
			end
			S_SPLIT: begin
				cmd.split = 1'b1;
				if (status.split_last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status.digit_done) begin
					if (status.last_digit) begin
						state_d = S_NL;
					end else begin
						cmd.next_digit = 1'b1;
					end
				end else if (status.out_free) begin
					cmd.step = 1'b1;
				end
			end
			S_NL: begin
				if (status.out_free) begin
					cmd.newline = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/rne_dp.sv */
// Datapath with the divide-by-ten splitter, digit and letter counters and the output register.
module rne_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rne_pkg::rne_cmd_t             cmd,
	output rne_pkg::rne_status_t          status,
	input  logic [rne_pkg::NUM_W-1:0]     number,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [rne_pkg::LETTER_W-1:0]  letter,
	output logic                          last_letter
);
	import rne_pkg::*;

	logic [NUM_W-1:0]    val_q;
	logic [DIGIT_W-1:0]  digits_q [4];
	logic [1:0]          split_cnt_q;
	logic [1:0]          dig_pos_q;
	logic [2:0]          let_pos_q;
	logic                out_valid_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;

	logic [PROD_W-1:0]   prod;
	logic [QUOT_W-1:0]   quot;
	logic [NUM_W-1:0]    quot_ten;
	logic [DIGIT_W-1:0]  rem;
	logic [DIGIT_W-1:0]  cur_dig;
	logic [2:0]          cur_len;

	assign prod = PROD_W'(val_q) * PROD_W'(RECIP_TEN);
	assign quot = prod[PROD_W-1:RECIP_SHIFT];
	assign quot_ten = NUM_W'({quot, 3'b000}) + NUM_W'({quot, 1'b0});
	assign rem = DIGIT_W'(val_q - quot_ten);

	assign cur_dig = digits_q[dig_pos_q];
	assign cur_len = digit_len(dig_pos_q, cur_dig);

	assign status.split_last = (split_cnt_q == SPLIT_LAST);
	assign status.digit_done = (let_pos_q >= cur_len);
	assign status.last_digit = (dig_pos_q == POS_UNITS);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign letter = letter_q;
	assign last_letter = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_cnt_q <= '0;
			dig_pos_q <= '0;
			let_pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				split_cnt_q <= '0;
				dig_pos_q <= POS_THOUSANDS;
				let_pos_q <= '0;
			end else if (cmd.split) begin
				split_cnt_q <= split_cnt_q + 2'd1;
			end else if (cmd.next_digit) begin
				dig_pos_q <= dig_pos_q - 2'd1;
				let_pos_q <= '0;
			end else if (cmd.step) begin
				let_pos_q <= let_pos_q + 3'd1;
			end
			if (cmd.step || cmd.newline) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= number;
		end else if (cmd.split) begin
			val_q <= NUM_W'(quot);
			digits_q[split_cnt_q] <= rem;
			if (split_cnt_q == SPLIT_LAST) begin
				digits_q[POS_THOUSANDS] <= quot[DIGIT_W-1:0];
			end
		end
		if (cmd.step) begin
			letter_q <= letter_code(dig_pos_q, cur_dig, let_pos_q);
			last_q <= 1'b0;
		end else if (cmd.newline) begin
			letter_q <= CODE_NL;
			last_q <= 1'b1;
		end
	end

endmodule

/* src/roman_numeral_encoder_top.sv */
// Top level of the Roman numeral encoder.
// Each input word is a binary number, meant for 0 to 3999, that comes out as a run of ASCII
// Roman numeral letters, one letter per output word, most significant digit first and closed
// by a newline word with last_letter set; zero gives the newline alone, and a number of 4000
// or more gives no thousands letters. After the input word is taken, multiply-by-reciprocal
// division splits it into decimal digits, then the output register moves one letter per cycle
// while the sink does not stall, with a pause at each of the four digit positions and then
// the closing newline. The next number is taken while the closing newline still waits in the
// output register.
module roman_numeral_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	rne_in_if.sink      din,
	rne_out_if.source   dout
);
	import rne_pkg::*;

	rne_cmd_t    cmd;
	rne_status_t status;

	rne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.status   (status),
		.cmd      (cmd)
	);

	rne_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.number      (din.number),
		.out_ready   (dout.ready),
		.out_valid   (dout.valid),
		.letter      (dout.letter),
		.last_letter (dout.last_letter)
	);

	a_last_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.last_letter |-> dout.letter == CODE_NL)
		else $error("closing word is not a newline");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid && din.ready |=> !din.ready)
		else $error("input taken again before the run finished");

	a_idle_only_newline_pending: assert property (@(posedge clk) disable iff (!arst_n)
		din.ready && dout.valid |-> dout.last_letter)
		else $error("ready for a new number while letters are still pending");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench of the Roman numeral encoder top level.
`timescale 1ns / 1ps

module tb;
	import rne_pkg::*;

	typedef struct {
		logic [LETTER_W-1:0] code;
		logic last;
	} numeral_letter_t;

	logic clk;
	logic arst_n;

	rne_in_if in_ch ();
	rne_out_if out_ch ();

	roman_numeral_encoder_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(in_ch),
		.dout(out_ch)
	);

	numeral_letter_t pending_letters[$];
	int unsigned mismatch_count;
	int unsigned stall_left;
	bit steady;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void push_letter(input logic [LETTER_W-1:0] code, input logic last);
		numeral_letter_t entry;
		entry.code = code;
		entry.last = last;
		pending_letters.push_back(entry);
	endfunction

	function automatic void predict_numeral(input logic [NUM_W-1:0] num);
		int unsigned value;
		int unsigned digit;
		int unsigned thousands;
		logic [LETTER_W-1:0] one_code;
		logic [LETTER_W-1:0] five_code;
		logic [LETTER_W-1:0] ten_code;
		value = 32'(num);
		thousands = value / 1000;
		if (thousands >= 1 && thousands <= 3) begin
			repeat (thousands) push_letter(CODE_M, 1'b0);
		end
		for (int pos = 2; pos >= 0; pos--) begin
			case (pos)
				2: begin
					digit = (value / 100) % 10;
					one_code = CODE_C;
					five_code = CODE_D;
					ten_code = CODE_M;
				end
				1: begin
					digit = (value / 10) % 10;
					one_code = CODE_X;
					five_code = CODE_L;
					ten_code = CODE_C;
				end
				default: begin
					digit = value % 10;
					one_code = CODE_I;
					five_code = CODE_V;
					ten_code = CODE_X;
				end
			endcase
			case (digit)
				1, 2, 3: repeat (digit) push_letter(one_code, 1'b0);
				4: begin
					push_letter(one_code, 1'b0);
					push_letter(five_code, 1'b0);
				end
				5, 6, 7, 8: begin
					push_letter(five_code, 1'b0);
					repeat (digit - 5) push_letter(one_code, 1'b0);
				end
				9: begin
					push_letter(one_code, 1'b0);
					push_letter(ten_code, 1'b0);
				end
				default: ;
			endcase
		end
		push_letter(CODE_NL, 1'b1);
	endfunction

	task automatic send_number(input logic [NUM_W-1:0] num);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.number = num;
		do @(posedge clk); while (!in_ch.ready);
		predict_numeral(num);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_letters.size() != 0) @(posedge clk);
	endtask

	task automatic test_corner_numbers();
		logic [NUM_W-1:0] corners [23];
		corners = '{12'd0, 12'd3999, 12'd3888, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40,
			12'd90, 12'd400, 12'd900, 12'd1000, 12'd2000, 12'd3000, 12'd4000, 12'd4095,
			12'd1994, 12'd444, 12'd999, 12'd2749, 12'd3276, 12'd4088};
		foreach (corners[i]) send_number(corners[i]);
	endtask

	task automatic test_random_numbers(input int unsigned count);
		logic [NUM_W-1:0] num;
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				num = NUM_W'($urandom_range(4000, 4095));
			end else if (pick < 4) begin
				num = NUM_W'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
					+ $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
			end else begin
				num = NUM_W'($urandom_range(0, 3999));
			end
			send_number(num);
		end
	endtask

	task automatic test_back_to_back(input int unsigned count);
		steady = 1'b1;
		repeat (count) send_number(NUM_W'($urandom_range(0, 3999)));
		steady = 1'b0;
	endtask

	task automatic test_drain_pause(input int unsigned count);
		repeat (count) begin
			send_number(NUM_W'($urandom_range(0, 4095)));
			in_ch.valid = 1'b0;
			wait_drained();
			@(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		numeral_letter_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_letters.size() == 0) begin
				$display("%0t: unexpected word letter=%0d last_letter=%0b", $time,
					out_ch.letter, out_ch.last_letter);
				mismatch_count++;
			end else begin
				want = pending_letters.pop_front();
				if (out_ch.letter !== want.code) begin
					$display("%0t: letter expected %0d actual %0d", $time, want.code,
						out_ch.letter);
					mismatch_count++;
				end
				if (out_ch.last_letter !== want.last) begin
					$display("%0t: last_letter expected %0b actual %0b", $time, want.last,
						out_ch.last_letter);
					mismatch_count++;
				end
			end
			stall_left = steady ? 0 : $urandom_range(0, 13);
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("** roman_numeral_encoder_top: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.number = '0;
		out_ch.ready = 1'b0;
		mismatch_count = 0;
		stall_left = 0;
		steady = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_corner_numbers();
		test_random_numbers(150);
		test_back_to_back(40);
		test_drain_pause(8);
		test_random_numbers(150);
		in_ch.valid = 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("** roman_numeral_encoder_top: PASSED **");
		end else begin
			$display("** roman_numeral_encoder_top: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/rne_pkg.sv
src/rne_in_if.sv
src/rne_out_if.sv
src/rne_ctrl.sv
src/rne_dp.sv
src/roman_numeral_encoder_top.sv
tb/sv/tb.sv
